// ----- hw/rtl/gawr_pkg.sv -----
// ----------------------------------------------------------------------------
// gawr_pkg
// Shared types, codes and helpers of the glyph and rectangle pixel writer.
// ----------------------------------------------------------------------------
package gawr_pkg;

	localparam int MAX_RES    = 4096;
	localparam int RES_W      = $clog2(MAX_RES) + 1;
	localparam int COORD_W    = 13;
	localparam int POS_W      = COORD_W + 2;
	localparam int ADDR_W     = 32;
	localparam int DATA_W     = 32;
	localparam int PROD_W     = (RES_W - 1) + RES_W;
	localparam int OFFSET_W   = PROD_W + 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	// action codes
	localparam logic [1:0] ACT_START_GLYPH = 2'd0;
	localparam logic [1:0] ACT_START_FILL  = 2'd1;

	// pixel formats
	localparam logic [1:0] FMT_8BPP   = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_32BPP  = 2'd2;
	localparam logic [1:0] FMT_NONE   = 2'd3;

	// write sizes
	localparam logic [1:0] SIZE_BYTE = 2'd0;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_FMT   = 2'd1;
	localparam logic [1:0] ST_NO_REGION = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FRAME_BASE = 2'd0;
	localparam logic [1:0] REG_X_RES      = 2'd1;
	localparam logic [1:0] REG_Y_RES      = 2'd2;
	localparam logic [1:0] REG_PIX_FMT    = 2'd3;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_NO_REGION,
		KIND_PIXEL
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic               set;
		logic               done;
		logic [DATA_W-1:0]  color;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  frame_base;
		logic [COORD_W-1:0] x_res;
		logic [COORD_W-1:0] y_res;
		logic [1:0]         pixel_format;
	} cfg_t;

	function automatic logic [RES_W-1:0] clamp_res(input logic [COORD_W-1:0] r);
		logic [RES_W-1:0] res;
		if (32'(r) > 32'(MAX_RES))
			res = RES_W'(MAX_RES);
		else
			res = RES_W'(r);
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] convert_color(input logic [DATA_W-1:0] c,
			input logic [1:0] fmt);
		logic [DATA_W-1:0] res;
		case (fmt)
			FMT_8BPP:   res = {24'd0, c[7:0]};
			FMT_RGB565: res = {16'd0, c[23:19], c[15:10], c[7:3]};
			default:    res = c;
		endcase
		return res;
	endfunction

endpackage

// ----- hw/rtl/gawr_front.sv -----
// ----------------------------------------------------------------------------
// gawr_front
// Accepts items, keeps the open region and its walk, issues one command each.
// ----------------------------------------------------------------------------
module gawr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   action,
	input  logic [gawr_pkg::COORD_W-1:0] start_x,
	input  logic [gawr_pkg::COORD_W-1:0] start_y,
	input  logic [gawr_pkg::COORD_W-1:0] region_width,
	input  logic [gawr_pkg::COORD_W-1:0] region_height,
	input  logic [gawr_pkg::DATA_W-1:0]  color,
	input  logic [7:0]                   pixel_mask,
	output gawr_pkg::cmd_t               cmd
);

	localparam int CW = gawr_pkg::COORD_W;

	logic [CW-1:0]              origin_x_q, origin_y_q, span_w_q, span_h_q;
	logic [CW-1:0]              col_q, row_q;
	logic [gawr_pkg::DATA_W-1:0] color_q;
	logic                       fill_q, active_q;

	logic          is_start;
	logic [CW:0]   col_inc, row_inc;
	logic [CW-1:0] col_n, row_n;
	logic          done;

	always_comb begin
		is_start = action inside {gawr_pkg::ACT_START_GLYPH, gawr_pkg::ACT_START_FILL};
		col_inc  = {1'b0, col_q} + 1'b1;
		row_inc  = {1'b0, row_q} + 1'b1;
		col_n    = col_q;
		row_n    = row_q;
		done     = 1'b0;
		if (fill_q) begin
			if (col_inc >= {1'b0, span_w_q}) begin
				col_n = '0;
				row_n = row_inc[CW-1:0];
				done  = row_inc >= {1'b0, span_h_q};
			end else begin
				col_n = col_inc[CW-1:0];
			end
		end else begin
			if (row_inc >= {1'b0, span_h_q}) begin
				row_n = '0;
				col_n = col_inc[CW-1:0];
				done  = col_inc >= {1'b0, span_w_q};
			end else begin
				row_n = row_inc[CW-1:0];
			end
		end
	end

	always_comb begin
		cmd.x     = {{2{origin_x_q[CW-1]}}, origin_x_q} + {2'b00, col_q};
		cmd.y     = {{2{origin_y_q[CW-1]}}, origin_y_q} + {2'b00, row_q};
		cmd.set   = fill_q || (pixel_mask != 8'd0);
		cmd.done  = 1'b0;
		cmd.color = color_q;
		if (is_start) begin
			cmd.kind = gawr_pkg::KIND_START;
		end else if (!active_q) begin
			cmd.kind = gawr_pkg::KIND_NO_REGION;
		end else begin
			cmd.kind = gawr_pkg::KIND_PIXEL;
			cmd.done = done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			span_w_q   <= '0;
			span_h_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			color_q    <= '0;
			fill_q     <= 1'b0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				origin_x_q <= start_x;
				origin_y_q <= start_y;
				span_w_q   <= region_width;
				span_h_q   <= region_height;
				color_q    <= color;
				fill_q     <= action == gawr_pkg::ACT_START_FILL;
				col_q      <= '0;
				row_q      <= '0;
				active_q   <= (region_width != '0) && (region_height != '0);
			end else if (active_q) begin
				if (done) begin
					col_q    <= '0;
					row_q    <= '0;
					active_q <= 1'b0;
				end else begin
					col_q <= col_n;
					row_q <= row_n;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/gawr_queue.sv -----
// ----------------------------------------------------------------------------
// gawr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gawr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gawr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output gawr_pkg::cmd_t head
);

	localparam int D  = gawr_pkg::QUEUE_DEPTH;
	localparam int PW = gawr_pkg::QPTR_W;

	gawr_pkg::cmd_t slots_q [D];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW:0]    count_q;

	assign full      = count_q == (PW+1)'(D);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/gawr_back.sv -----
// ----------------------------------------------------------------------------
// gawr_back
// Clips, converts and addresses each command; holds the output register.
// ----------------------------------------------------------------------------
module gawr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gawr_pkg::cfg_t              cfg,
	input  logic                        cmd_valid,
	input  gawr_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        write_valid,
	output logic [gawr_pkg::ADDR_W-1:0] write_address,
	output logic [gawr_pkg::DATA_W-1:0] write_data,
	output logic [1:0]                  write_size,
	output logic                        region_done,
	output logic [1:0]                  status
);

	localparam int RW = gawr_pkg::RES_W;
	localparam int PW = gawr_pkg::POS_W;
	localparam int QW = gawr_pkg::PROD_W;
	localparam int OW = gawr_pkg::OFFSET_W;

	logic [RW-1:0] xres, yres;
	logic          on_screen, do_write;
	logic [1:0]    st;

	logic                        valid_s1;
	logic                        write_s1;
	logic [1:0]                  status_s1;
	logic                        done_s1;
	logic [gawr_pkg::DATA_W-1:0] data_s1;
	logic [QW-1:0]               prod_s1;
	logic [RW-2:0]               x_s1;

	logic          out_free, adv_s1;
	logic [QW-1:0] index;
	logic [OW-1:0] offset;

	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign cmd_pop  = cmd_valid && (!valid_s1 || adv_s1);

	always_comb begin
		xres      = gawr_pkg::clamp_res(cfg.x_res);
		yres      = gawr_pkg::clamp_res(cfg.y_res);
		on_screen = !cmd.x[PW-1] && !cmd.y[PW-1]
			&& (cmd.x[PW-2:0] < (PW-1)'(xres)) && (cmd.y[PW-2:0] < (PW-1)'(yres));
		do_write  = 1'b0;
		st        = gawr_pkg::ST_OK;
		case (cmd.kind)
			gawr_pkg::KIND_NO_REGION: st = gawr_pkg::ST_NO_REGION;
			gawr_pkg::KIND_PIXEL: begin
				if (on_screen && cmd.set) begin
					if (cfg.pixel_format == gawr_pkg::FMT_NONE)
						st = gawr_pkg::ST_BAD_FMT;
					else
						do_write = 1'b1;
				end
			end
			default: st = gawr_pkg::ST_OK;
		endcase
	end

	// row offset multiply, registered before the address add
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			write_s1  <= do_write;
			status_s1 <= st;
			done_s1   <= cmd.done;
			data_s1   <= gawr_pkg::convert_color(cmd.color, cfg.pixel_format);
			prod_s1   <= QW'(cmd.y[RW-2:0]) * QW'(xres);
			x_s1      <= cmd.x[RW-2:0];
		end
	end

	always_comb begin
		index = prod_s1 + {{(QW-RW+1){1'b0}}, x_s1};
		case (cfg.pixel_format)
			gawr_pkg::FMT_8BPP:   offset = {2'b00, index};
			gawr_pkg::FMT_RGB565: offset = {1'b0, index, 1'b0};
			default:              offset = {index, 2'b00};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			write_valid   <= write_s1;
			write_address <= write_s1
				? cfg.frame_base + {{(gawr_pkg::ADDR_W-OW){1'b0}}, offset} : '0;
			write_data    <= write_s1 ? data_s1 : '0;
			write_size    <= write_s1 ? cfg.pixel_format : gawr_pkg::SIZE_BYTE;
			region_done   <= done_s1;
			status        <= status_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd_pop)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (out_free)
				out_valid <= valid_s1;
		end
	end

endmodule

// ----- hw/rtl/glyph_and_rect_pixel_writer_unit.sv -----
// ----------------------------------------------------------------------------
// glyph_and_rect_pixel_writer_unit
// Glyph blit and rectangle fill pixel writer for a linear framebuffer.
// ----------------------------------------------------------------------------
// a result is held in the queue, the back stage register and the output register before it shows
// throughput: one item per cycle unless in_stall or out_stall holds it; set by the
//   walk counters and the one row multiply per pixel in the back stage
// a four-entry queue parts the front from the back; either side may stall
// reset: async, clears the walk, the queue and the pipeline, loads register defaults
module glyph_and_rect_pixel_writer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [gawr_pkg::COORD_W-1:0] start_x,
	input  logic [gawr_pkg::COORD_W-1:0] start_y,
	input  logic [gawr_pkg::COORD_W-1:0] region_width,
	input  logic [gawr_pkg::COORD_W-1:0] region_height,
	input  logic [gawr_pkg::DATA_W-1:0]  color,
	input  logic [7:0]                   pixel_mask,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         write_valid,
	output logic [gawr_pkg::ADDR_W-1:0]  write_address,
	output logic [gawr_pkg::DATA_W-1:0]  write_data,
	output logic [1:0]                   write_size,
	output logic                         region_done,
	output logic [1:0]                   status
);

	gawr_pkg::cfg_t cfg_q;
	gawr_pkg::cmd_t front_cmd, head_cmd;
	logic           q_full, q_not_empty, q_pop, accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base   <= '0;
			cfg_q.x_res        <= gawr_pkg::COORD_W'(1024);
			cfg_q.y_res        <= gawr_pkg::COORD_W'(600);
			cfg_q.pixel_format <= gawr_pkg::FMT_32BPP;
		end else if (cfg_write) begin
			case (cfg_index)
				gawr_pkg::REG_FRAME_BASE: cfg_q.frame_base   <= cfg_data;
				gawr_pkg::REG_X_RES:      cfg_q.x_res        <= cfg_data[gawr_pkg::COORD_W-1:0];
				gawr_pkg::REG_Y_RES:      cfg_q.y_res        <= cfg_data[gawr_pkg::COORD_W-1:0];
				gawr_pkg::REG_PIX_FMT:    cfg_q.pixel_format <= cfg_data[1:0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	gawr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.start_x      (start_x),
		.start_y      (start_y),
		.region_width (region_width),
		.region_height(region_height),
		.color        (color),
		.pixel_mask   (pixel_mask),
		.cmd          (front_cmd)
	);

	gawr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (head_cmd)
	);

	gawr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_valid  (write_valid),
		.write_address(write_address),
		.write_data   (write_data),
		.write_size   (write_size),
		.region_done  (region_done),
		.status       (status)
	);

	// a write carries ok status and the size of the current format
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> status == gawr_pkg::ST_OK
			&& write_size == cfg_q.pixel_format)
		else $error("write beat with bad status or size");

	// no write means an all-zero write payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_address == '0 && write_data == '0
			&& write_size == gawr_pkg::SIZE_BYTE)
		else $error("idle write payload not zero");

	// region end never comes with a missing region
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_done |-> status != gawr_pkg::ST_NO_REGION)
		else $error("region done without a region");

	// the queue pops only when it holds an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("pop from empty queue");

endmodule
